// File: sv/fpat_pkg.sv
// Shared types and constants for the fixed-point amount to decimal text block.
// No dependencies; every other file imports this package.
package fpat_pkg;

    localparam int AMT_W      = 64;
    localparam int SYM_W      = 64;
    localparam int CHAR_W     = 8;
    localparam int PREC_W     = 5;   // holds 0..18 once range checked
    localparam int NUM_DIGITS = 20;  // 2^63 has 19 digits, 2^64-1 has 20
    localparam int DIG_IDX_W  = 5;
    localparam int TICK_BYTES = 7;
    localparam int TLEN_W     = 3;
    localparam int BIT_CNT_W  = 6;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic signed [AMT_W-1:0] amount;
        logic [SYM_W-1:0]        symbol_word;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
        logic              error;
    } t_out;

    // Classified job handed from front to back
    typedef struct packed {
        logic                       err;
        logic                       neg;
        logic [AMT_W-1:0]           mag;
        logic [PREC_W-1:0]          prec;
        logic [TICK_BYTES*8-1:0]    tick;
        logic [TLEN_W-1:0]          tlen;
    } t_job;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIND,
        ST_ERR,
        ST_SIGN,
        ST_INT,
        ST_POINT,
        ST_FRAC,
        ST_SPACE,
        ST_TICK
    } t_state;

endpackage

// File: sv/fixed_point_asset_to_decimal_text_top.sv
// Top level of the fixed-point amount to decimal text formatter.
// Instantiates fpat_front, fpat_job_q and fpat_back; uses fpat_pkg.
//
// Each input word carries a signed 64-bit amount and a symbol word (low byte
// precision, bytes 1..7 ticker, zero terminated). The block answers with one
// output word per character: optional '-', integer digits, '.', exactly
// precision fraction digits, ' ', ticker characters; last marks the final
// character. A precision above MAX_PRECISION yields a single word with char 0,
// last 1 and error 1. An item is held in the front register, then the back end
// converts the magnitude to BCD with a shift-and-add-3 loop over all 64 bits,
// locates the leading digit, then emits one character per cycle while the output
// queue has room, up to 29 characters per item. The two-entry job queue lets the
// front accept up to three further items while the back works; a two-entry output
// queue lets emission run ahead of pop.
module fixed_point_asset_to_decimal_text_top #(
    parameter int MAX_PRECISION = 18,
    parameter int TICKER_CHARS  = 7
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           push,
    output logic           full,
    input  fpat_pkg::t_in  i_in_word,
    output logic           empty,
    input  logic           pop,
    output fpat_pkg::t_out o_out_word
);
    import fpat_pkg::*;

    logic front_vld;
    t_job front_job;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job q_job;

    // classify and register incoming words
    fpat_front #(
        .MAX_PRECISION (MAX_PRECISION),
        .TICKER_CHARS  (TICKER_CHARS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (i_in_word),
        .o_job_vld  (front_vld),
        .o_job      (front_job),
        .i_job_full (q_full)
    );

    // decoupling queue
    fpat_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_vld),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    // BCD conversion and character sequencing
    fpat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (q_empty),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_out_word  (o_out_word)
    );

endmodule

// File: sv/fpat_front.sv
// Front end: accepts input words, computes sign, magnitude, precision check
// and ticker length, and holds the classified job in one register. Uses fpat_pkg.
module fpat_front #(
    parameter int MAX_PRECISION = 18,
    parameter int TICKER_CHARS  = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  fpat_pkg::t_in i_in_word,
    output logic          o_job_vld,
    output fpat_pkg::t_job o_job,
    input  logic          i_job_full
);
    import fpat_pkg::*;

    logic              r_vld;
    t_job              r_job;
    t_job              n_job;
    logic [CHAR_W-1:0] prec8;
    logic              stop;

    always_comb begin
        prec8      = i_in_word.symbol_word[7:0];
        n_job.err  = prec8 > CHAR_W'(MAX_PRECISION);
        n_job.neg  = i_in_word.amount[AMT_W-1];
        n_job.mag  = n_job.neg ? (~i_in_word.amount + 64'd1) : i_in_word.amount;
        n_job.prec = prec8[PREC_W-1:0];
        n_job.tick = i_in_word.symbol_word[SYM_W-1:8];
        n_job.tlen = '0;
        stop       = 1'b0;
        for (int i = 0; i < TICK_BYTES; i++) begin
            if (!stop && (i < TICKER_CHARS) && (n_job.tick[i*8 +: 8] != CH_NUL)) begin
                n_job.tlen = n_job.tlen + TLEN_W'(1);
            end else begin
                stop = 1'b1;
            end
        end
    end

    assign full      = r_vld && i_job_full;
    assign o_job_vld = r_vld;
    assign o_job     = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!full) begin
            r_vld <= push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!full && push) begin
            r_job <= n_job;
        end
    end

endmodule

// File: sv/fpat_job_q.sv
// Two-entry job queue between front and back.
// Uses fpat_pkg for the job type.
module fpat_job_q (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fpat_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output fpat_pkg::t_job o_job
);
    import fpat_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == (PTR_W+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + PTR_W'(1);
            if (do_pop)  r_rp <= r_rp + PTR_W'(1);
            r_cnt <= r_cnt + (PTR_W+1)'(do_push) - (PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: sv/fpat_back.sv
// Back end: double-dabble conversion of the magnitude, one bit per cycle,
// then character sequencing into a two-entry output queue. Uses fpat_pkg.
module fpat_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_empty,
    input  fpat_pkg::t_job i_job,
    output logic           o_job_pop,
    output logic           empty,
    input  logic           pop,
    output fpat_pkg::t_out o_out_word
);
    import fpat_pkg::*;

    localparam int ODEPTH = 2;
    localparam int OPTR_W = $clog2(ODEPTH);

    t_state                          r_st, n_st;
    t_job                            r_job;
    logic [AMT_W-1:0]                r_bin;
    logic [NUM_DIGITS-1:0][3:0]      r_bcd;
    logic [NUM_DIGITS-1:0][3:0]      adj;
    logic [NUM_DIGITS*4-1:0]         adj_flat;
    logic [BIT_CNT_W-1:0]            r_cnt;
    logic [DIG_IDX_W-1:0]            r_idx;
    logic [DIG_IDX_W-1:0]            msd;
    logic [DIG_IDX_W-1:0]            start;
    logic [TLEN_W-1:0]               r_tk;
    logic [3:0]                      cur_dig;

    // character emitter
    logic  emit_vld;
    t_out  emit;
    logic  emit_go;

    // output queue
    t_out              r_omem [ODEPTH];
    logic [OPTR_W-1:0] r_owp;
    logic [OPTR_W-1:0] r_orp;
    logic [OPTR_W:0]   r_ocnt;
    logic              ofull;
    logic              opop;

    assign ofull   = r_ocnt == (OPTR_W+1)'(ODEPTH);
    assign empty   = r_ocnt == '0;
    assign o_out_word = r_omem[r_orp];
    assign opop    = pop && !empty;
    assign emit_go = emit_vld && !ofull;
    assign cur_dig = r_bcd[r_idx];
    assign o_job_pop = (r_st == ST_IDLE) && !i_job_empty;
    assign adj_flat = adj;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
    end

    always_comb begin
        msd = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[i] != 4'd0) msd = DIG_IDX_W'(i);
        end
        start = (msd > DIG_IDX_W'(r_job.prec)) ? msd : DIG_IDX_W'(r_job.prec);
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (!i_job_empty) n_st = i_job.err ? ST_ERR : ST_CONV;
            ST_CONV:  if (r_cnt == '1) n_st = ST_FIND;
            ST_FIND:  n_st = r_job.neg ? ST_SIGN : ST_INT;
            ST_ERR:   if (!ofull) n_st = ST_IDLE;
            ST_SIGN:  if (!ofull) n_st = ST_INT;
            ST_INT:   if (!ofull && r_idx == DIG_IDX_W'(r_job.prec)) n_st = ST_POINT;
            ST_POINT: if (!ofull) n_st = (r_job.prec == '0) ? ST_SPACE : ST_FRAC;
            ST_FRAC:  if (!ofull && r_idx == '0) n_st = ST_SPACE;
            ST_SPACE: if (!ofull) n_st = (r_job.tlen == '0) ? ST_IDLE : ST_TICK;
            ST_TICK:  if (!ofull && r_tk == r_job.tlen - TLEN_W'(1)) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // character outputs
    always_comb begin
        emit_vld       = 1'b1;
        emit.text_char = CH_NUL;
        emit.last      = 1'b0;
        emit.error     = 1'b0;
        unique case (r_st)
            ST_ERR: begin
                emit.last  = 1'b1;
                emit.error = 1'b1;
            end
            ST_SIGN:  emit.text_char = CH_MINUS;
            ST_INT, ST_FRAC: emit.text_char = CH_ZERO + CHAR_W'(cur_dig);
            ST_POINT: emit.text_char = CH_POINT;
            ST_SPACE: begin
                emit.text_char = CH_SPACE;
                emit.last      = r_job.tlen == '0;
            end
            ST_TICK: begin
                emit.text_char = r_job.tick[r_tk*8 +: 8];
                emit.last      = r_tk == r_job.tlen - TLEN_W'(1);
            end
            default: emit_vld = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: begin
                r_job <= i_job;
                r_bin <= i_job.mag;
                r_bcd <= '0;
                r_cnt <= '0;
            end
            ST_CONV: begin
                r_bcd <= {adj_flat[NUM_DIGITS*4-2:0], r_bin[AMT_W-1]};
                r_bin <= {r_bin[AMT_W-2:0], 1'b0};
                r_cnt <= r_cnt + BIT_CNT_W'(1);
            end
            ST_FIND: begin
                r_idx <= start;
                r_tk  <= '0;
            end
            ST_INT: begin
                if (!ofull && r_idx != '0) r_idx <= r_idx - DIG_IDX_W'(1);
            end
            ST_FRAC: begin
                if (!ofull && r_idx != '0) r_idx <= r_idx - DIG_IDX_W'(1);
            end
            ST_TICK: begin
                if (!ofull) r_tk <= r_tk + TLEN_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (emit_go) r_owp <= r_owp + OPTR_W'(1);
            if (opop)    r_orp <= r_orp + OPTR_W'(1);
            r_ocnt <= r_ocnt + (OPTR_W+1)'(emit_go) - (OPTR_W+1)'(opop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_omem[r_owp] <= emit;
        end
    end

    a_ocnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= (OPTR_W+1)'(ODEPTH))
        else $error("output queue overfilled");

    a_no_emit_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_CONV || r_st == ST_FIND) |-> !emit_vld)
        else $error("character emitted during conversion");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_go && emit.last) |=> r_st == ST_IDLE)
        else $error("sequencer kept running after last character");

    a_conv_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_FIND) |-> $past(r_st == ST_CONV) && r_cnt == '0)
        else $error("conversion did not run full length");

endmodule
